FILE: hdl/kcat_pkg.sv
// ----------------------------------------------------------------------------
// kcat_pkg
// Shared types and constants of the keyed count aggregation table.
// ----------------------------------------------------------------------------
package kcat_pkg;

	// Default sizes handed to the top level parameters.
	localparam int BUCKETS_DEF = 1024;
	localparam int ENTRIES_DEF = 4096;
	localparam int SAMPLES_DEF = 256;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH = 2;

	// Configuration port.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE  = 8'd1;
	localparam logic [7:0] TARGET_RESET = 8'd109;

	// Character codes.
	localparam logic [7:0] CODE_PLUS  = 8'd43;
	localparam logic [7:0] CODE_MINUS = 8'd45;
	localparam logic [7:0] CODE_M     = 8'd109;
	localparam logic [7:0] CODE_H     = 8'd104;
	localparam logic [7:0] CODE_C     = 8'd99;
	localparam logic [7:0] CODE_G     = 8'd103;

	// Hash constants.
	localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
	localparam int HASH_SHIFT = 16;

	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

	// Request functions.
	localparam logic FUNC_ACCUM  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_NEW      = 3'd1,
		ST_FILTERED = 3'd2,
		ST_FULL     = 3'd3,
		ST_HIT      = 3'd4,
		ST_MISS     = 3'd5
	} status_t;

	typedef enum logic {
		KIND_FILTERED = 1'b0,
		KIND_KEYED    = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MIX,
		F_FOLD,
		F_MUL,
		F_SUB,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_HEAD,
		B_CMP
	} back_state_t;

	// Configuration registers as seen by the front part.
	typedef struct packed {
		logic [7:0] target_code;
		logic       merge_strands;
	} cfg_t;

	// One classified request passed from front to back.
	typedef struct packed {
		kind_t       kind;
		logic        func;
		logic [31:0] kpos;
		logic [7:0]  strand;
		logic [7:0]  code;
		logic [7:0]  sample;
		logic [15:0] add_mod;
		logic [15:0] add_can;
		logic [15:0] add_cov;
	} job_t;

	// One result.
	typedef struct packed {
		status_t     status;
		logic [31:0] tot_mod;
		logic [31:0] tot_can;
		logic [31:0] tot_cov;
		logic        sat;
		logic [31:0] kpos;
	} res_t;

endpackage

FILE: hdl/kcat_fifo.sv
// ----------------------------------------------------------------------------
// kcat_fifo
// Small register queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module kcat_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = kcat_pkg::QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             is_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             is_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [AW:0]      count_q;
	logic             do_wr, do_rd;

	assign is_full  = (count_q == (AW+1)'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = slot_q[rptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: hdl/kcat_front.sv
// ----------------------------------------------------------------------------
// kcat_front
// Accepts records, filters them, folds strands and hashes the key to a bucket.
// ----------------------------------------------------------------------------
module kcat_front #(
	parameter int BUCKETS = kcat_pkg::BUCKETS_DEF,
	parameter int SAMPLES = kcat_pkg::SAMPLES_DEF,
	parameter int BI      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kcat_pkg::cfg_t      cfg,
	input  logic                in_push,
	output logic                in_full,
	input  logic                func,
	input  logic [30:0]         position,
	input  logic [7:0]          strand_char,
	input  logic [7:0]          mod_char,
	input  logic [7:0]          sample_index,
	input  logic [15:0]         modified_count,
	input  logic [15:0]         canonical_count,
	input  logic [15:0]         coverage_count,
	output logic                q_push,
	output kcat_pkg::job_t      q_job,
	output logic [BI-1:0]       q_bucket,
	input  logic                q_full
);
	localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
	// Reciprocal of the bucket count, scaled by 2^32 and rounded down.
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);

	kcat_pkg::front_state_t state_q, state_nxt;
	kcat_pkg::job_t         job_q;
	logic [31:0]            h_q;
	logic                   mix_cnt_q;
	logic [31:0]            quo_q;
	logic [BI-1:0]          rem_q;
	logic                   accept, filt, fold;
	logic [31:0]            kpos, h0, h_fold;
	logic [7:0]             kstr;
	logic [63:0]            recip_prod;

	function automatic logic [31:0] mul31(input logic [31:0] x);
		mul31 = {x[26:0], 5'b0} - x;
	endfunction

	assign accept = in_push && (state_q == kcat_pkg::F_IDLE);

	// Classification and strand fold of an incoming record.
	always_comb begin
		filt = (mod_char != cfg.target_code) || (32'(sample_index) >= 32'(SAMPLES));
		fold = cfg.merge_strands &&
			((cfg.target_code == kcat_pkg::CODE_M) || (cfg.target_code == kcat_pkg::CODE_H) ||
			 (cfg.target_code == kcat_pkg::CODE_C) || (cfg.target_code == kcat_pkg::CODE_G));
		kpos = {1'b0, position};
		kstr = strand_char;
		if (!filt && fold) begin
			if (strand_char == kcat_pkg::CODE_MINUS) begin
				kpos = {1'b0, position} - 32'd1;
			end
			kstr = kcat_pkg::CODE_PLUS;
		end
		h0 = mul31(mul31(mul31(kpos) + 32'(kstr)) + 32'(mod_char)) + 32'(sample_index);
	end

	assign h_fold     = (h_q >> kcat_pkg::HASH_SHIFT) ^ h_q;
	assign recip_prod = 64'(h_q) * 64'(RECIP);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kcat_pkg::F_IDLE: begin
				if (in_push) begin
					state_nxt = filt ? kcat_pkg::F_PUSH : kcat_pkg::F_MIX;
				end
			end
			kcat_pkg::F_MIX: begin
				if (mix_cnt_q) begin
					state_nxt = kcat_pkg::F_FOLD;
				end
			end
			kcat_pkg::F_FOLD: begin
				state_nxt = POW2 ? kcat_pkg::F_PUSH : kcat_pkg::F_MUL;
			end
			kcat_pkg::F_MUL: begin
				state_nxt = kcat_pkg::F_SUB;
			end
			kcat_pkg::F_SUB: begin
				state_nxt = kcat_pkg::F_MOD;
			end
			kcat_pkg::F_MOD: begin
				state_nxt = kcat_pkg::F_PUSH;
			end
			kcat_pkg::F_PUSH: begin
				if (!q_full) begin
					state_nxt = kcat_pkg::F_IDLE;
				end
			end
			default: state_nxt = kcat_pkg::F_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_full  = (state_q != kcat_pkg::F_IDLE);
		q_push   = (state_q == kcat_pkg::F_PUSH) && !q_full;
		q_job    = job_q;
		q_bucket = POW2 ? h_q[BI-1:0] : rem_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcat_pkg::F_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hash datapath: two mixing multiplies and a final fold. When BUCKETS is not a
	// power of two, the bucket remainder comes from a reciprocal multiply that
	// underestimates the quotient by at most one, a subtract, and one correction.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.kind    <= filt ? kcat_pkg::KIND_FILTERED : kcat_pkg::KIND_KEYED;
			job_q.func    <= func;
			job_q.kpos    <= kpos;
			job_q.strand  <= kstr;
			job_q.code    <= mod_char;
			job_q.sample  <= sample_index;
			job_q.add_mod <= modified_count;
			job_q.add_can <= canonical_count;
			job_q.add_cov <= coverage_count;
			h_q           <= h0;
			mix_cnt_q     <= 1'b0;
		end
		if (state_q == kcat_pkg::F_MIX) begin
			h_q       <= 32'(h_fold * kcat_pkg::HASH_MUL);
			mix_cnt_q <= 1'b1;
		end
		if (state_q == kcat_pkg::F_FOLD) begin
			h_q <= h_fold;
		end
		if (state_q == kcat_pkg::F_MUL) begin
			quo_q <= recip_prod[63:32];
		end
		if (state_q == kcat_pkg::F_SUB) begin
			h_q <= h_q - 32'(quo_q * 32'(BUCKETS));
		end
		if (state_q == kcat_pkg::F_MOD) begin
			rem_q <= (h_q >= 32'(BUCKETS)) ? BI'(h_q - 32'(BUCKETS)) : BI'(h_q);
		end
	end
endmodule

FILE: hdl/kcat_back.sv
// ----------------------------------------------------------------------------
// kcat_back
// Walks the bucket chain, updates or allocates entries and holds the result.
// ----------------------------------------------------------------------------
module kcat_back #(
	parameter int BUCKETS = kcat_pkg::BUCKETS_DEF,
	parameter int ENTRIES = kcat_pkg::ENTRIES_DEF,
	parameter int BI      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic           clearing,
	input  kcat_pkg::job_t q_job,
	input  logic [BI-1:0]  q_bucket,
	input  logic           q_empty,
	output logic           q_pop,
	output kcat_pkg::res_t res,
	output logic           res_valid,
	input  logic           res_pop
);
	localparam int EI = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Link word: valid bit over an entry index.
	typedef struct packed {
		logic          valid;
		logic [EI-1:0] idx;
	} link_t;

	link_t       head_mem [BUCKETS];
	logic [55:0] key_mem  [ENTRIES];
	logic [95:0] tot_mem  [ENTRIES];
	link_t       next_mem [ENTRIES];

	kcat_pkg::back_state_t state_q, state_nxt;
	kcat_pkg::job_t        job_q;
	kcat_pkg::res_t        res_q, res_d;
	logic                  res_valid_q, res_load;
	logic [BI-1:0]         bkt_q, clr_cnt_q;
	logic [EI:0]           used_q;
	logic [EI-1:0]         cur_q, cur_d, ent_raddr;
	link_t                 head_rd, head_q, head_cur, next_rd, head_wdata;
	logic [55:0]           key_rd, job_key;
	logic [95:0]           tot_rd, tot_wdata;
	logic                  head_we, new_we, tot_we, cur_we;
	logic [BI-1:0]         head_waddr;
	logic [EI-1:0]         tot_waddr;
	logic                  hit, miss_now, pool_empty, can_start;
	logic [32:0]           s_mod, s_can, s_cov;

	function automatic logic [32:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'b0, b};
		sat_add = s[32] ? {1'b1, kcat_pkg::TOTAL_MAX} : s;
	endfunction

	assign job_key    = {job_q.kpos, job_q.strand, job_q.code, job_q.sample};
	assign hit        = (key_rd == job_key);
	assign pool_empty = (used_q == (EI+1)'(ENTRIES));
	assign can_start  = !q_empty && (!res_valid_q || res_pop);
	assign head_cur   = (state_q == kcat_pkg::B_HEAD) ? head_rd : head_q;
	assign s_mod      = sat_add(tot_rd[95:64], job_q.add_mod);
	assign s_can      = sat_add(tot_rd[63:32], job_q.add_can);
	assign s_cov      = sat_add(tot_rd[31:0], job_q.add_cov);

	// The chain ends here without a match.
	assign miss_now = ((state_q == kcat_pkg::B_HEAD) && !head_rd.valid) ||
		((state_q == kcat_pkg::B_CMP) && !hit && !next_rd.valid);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kcat_pkg::B_CLEAR: begin
				if (clr_cnt_q == BI'(BUCKETS - 1)) begin
					state_nxt = kcat_pkg::B_IDLE;
				end
			end
			kcat_pkg::B_IDLE: begin
				if (can_start && (q_job.kind == kcat_pkg::KIND_KEYED)) begin
					state_nxt = kcat_pkg::B_HEAD;
				end
			end
			kcat_pkg::B_HEAD: begin
				state_nxt = head_rd.valid ? kcat_pkg::B_CMP : kcat_pkg::B_IDLE;
			end
			kcat_pkg::B_CMP: begin
				if (hit || !next_rd.valid) begin
					state_nxt = kcat_pkg::B_IDLE;
				end
			end
			default: state_nxt = kcat_pkg::B_IDLE;
		endcase
	end

	// Outputs: memory controls and the result to load.
	always_comb begin
		clearing   = (state_q == kcat_pkg::B_CLEAR);
		q_pop      = (state_q == kcat_pkg::B_IDLE) && can_start;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = '0;
		new_we     = 1'b0;
		tot_we     = 1'b0;
		tot_waddr  = cur_q;
		tot_wdata  = {s_mod[31:0], s_can[31:0], s_cov[31:0]};
		cur_we     = 1'b0;
		cur_d      = cur_q;
		ent_raddr  = cur_q;
		res_load   = 1'b0;
		res_d      = '0;
		res_d.kpos = job_q.kpos;
		unique case (state_q)
			kcat_pkg::B_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_cnt_q;
			end
			kcat_pkg::B_IDLE: begin
				if (q_pop && (q_job.kind == kcat_pkg::KIND_FILTERED)) begin
					res_load     = 1'b1;
					res_d.status = kcat_pkg::ST_FILTERED;
					res_d.kpos   = q_job.kpos;
				end
			end
			kcat_pkg::B_HEAD: begin
				ent_raddr = head_rd.idx;
				cur_we    = head_rd.valid;
				cur_d     = head_rd.idx;
			end
			kcat_pkg::B_CMP: begin
				if (hit) begin
					res_load = 1'b1;
					if (job_q.func == kcat_pkg::FUNC_LOOKUP) begin
						res_d.status  = kcat_pkg::ST_HIT;
						res_d.tot_mod = tot_rd[95:64];
						res_d.tot_can = tot_rd[63:32];
						res_d.tot_cov = tot_rd[31:0];
					end else begin
						tot_we        = 1'b1;
						res_d.status  = kcat_pkg::ST_ADDED;
						res_d.tot_mod = s_mod[31:0];
						res_d.tot_can = s_can[31:0];
						res_d.tot_cov = s_cov[31:0];
						res_d.sat     = s_mod[32] | s_can[32] | s_cov[32];
					end
				end else if (next_rd.valid) begin
					ent_raddr = next_rd.idx;
					cur_we    = 1'b1;
					cur_d     = next_rd.idx;
				end
			end
			default: ;
		endcase

		// Miss: report, or take a new entry and link it at the chain head.
		if (miss_now) begin
			res_load = 1'b1;
			if (job_q.func == kcat_pkg::FUNC_LOOKUP) begin
				res_d.status = kcat_pkg::ST_MISS;
			end else if (pool_empty) begin
				res_d.status = kcat_pkg::ST_FULL;
			end else begin
				new_we        = 1'b1;
				tot_we        = 1'b1;
				tot_waddr     = used_q[EI-1:0];
				tot_wdata     = {16'b0, job_q.add_mod, 16'b0, job_q.add_can,
					16'b0, job_q.add_cov};
				head_we       = 1'b1;
				head_wdata    = '{valid: 1'b1, idx: used_q[EI-1:0]};
				res_d.status  = kcat_pkg::ST_NEW;
				res_d.tot_mod = {16'b0, job_q.add_mod};
				res_d.tot_can = {16'b0, job_q.add_can};
				res_d.tot_cov = {16'b0, job_q.add_cov};
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	// Bucket head memory.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd <= head_mem[q_bucket];
	end

	// Entry memories.
	always_ff @(posedge clk) begin
		if (new_we) begin
			key_mem[used_q[EI-1:0]]  <= job_key;
			next_mem[used_q[EI-1:0]] <= head_cur;
		end
		if (tot_we) begin
			tot_mem[tot_waddr] <= tot_wdata;
		end
		key_rd  <= key_mem[ent_raddr];
		tot_rd  <= tot_mem[ent_raddr];
		next_rd <= next_mem[ent_raddr];
	end

	// Request payload and walk registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			bkt_q <= q_bucket;
		end
		if (state_q == kcat_pkg::B_HEAD) begin
			head_q <= head_rd;
		end
		if (cur_we) begin
			cur_q <= cur_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcat_pkg::B_CLEAR;
			clr_cnt_q   <= '0;
			used_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == kcat_pkg::B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (new_we) begin
				used_q <= used_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: hdl/keyed_count_aggregation_table.sv
// ----------------------------------------------------------------------------
// keyed_count_aggregation_table
// Hash table that sums per-site read counts, with a fixed entry pool.
// ----------------------------------------------------------------------------
// Records are pushed in and results popped out, one result per record, in
// order. The front part filters a record, folds its strand and hashes the key
// through its mixing and fold states; when BUCKETS is not a power of two the
// bucket remainder then takes a reciprocal multiply, a subtract and a
// correction step, and a filtered record goes straight to the push state. The
// back part reads the bucket head and then compares the chain entries in turn,
// through the registered reads of the bucket and entry memories; a filtered
// record is answered from its idle state. A two-entry queue between the parts
// lets the front hash the next record while the back walks a chain. After
// reset a clearing pass over every bucket head empties them, and full stays
// high until it ends. Configuration writes are always taken.
module keyed_count_aggregation_table #(
	parameter int BUCKETS = kcat_pkg::BUCKETS_DEF,
	parameter int ENTRIES = kcat_pkg::ENTRIES_DEF,
	parameter int SAMPLES = kcat_pkg::SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kcat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          func,
	input  logic [30:0]                   position,
	input  logic [7:0]                    strand_char,
	input  logic [7:0]                    mod_char,
	input  logic [7:0]                    sample_index,
	input  logic [15:0]                   modified_count,
	input  logic [15:0]                   canonical_count,
	input  logic [15:0]                   coverage_count,
	output logic                          empty,
	input  logic                          pop,
	output logic [2:0]                    status,
	output logic [31:0]                   total_modified,
	output logic [31:0]                   total_canonical,
	output logic [31:0]                   total_coverage,
	output logic                          saturated,
	output logic signed [31:0]            key_position
);
	localparam int BI = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW = BI + $bits(kcat_pkg::job_t);

	kcat_pkg::cfg_t cfg_q;
	kcat_pkg::job_t f_job, b_job;
	kcat_pkg::res_t res;
	logic [BI-1:0]  f_bucket, b_bucket;
	logic           clearing, front_full, f_push, q_full, q_empty, q_pop, res_valid;
	logic [QW-1:0]  q_rd;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_code   <= kcat_pkg::TARGET_RESET;
			cfg_q.merge_strands <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kcat_pkg::CFG_TARGET: cfg_q.target_code   <= cfg_data;
				kcat_pkg::CFG_MERGE:  cfg_q.merge_strands <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign full = front_full || clearing;

	kcat_front #(
		.BUCKETS (BUCKETS),
		.SAMPLES (SAMPLES),
		.BI      (BI)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_push         (push && !clearing),
		.in_full         (front_full),
		.func            (func),
		.position        (position),
		.strand_char     (strand_char),
		.mod_char        (mod_char),
		.sample_index    (sample_index),
		.modified_count  (modified_count),
		.canonical_count (canonical_count),
		.coverage_count  (coverage_count),
		.q_push          (f_push),
		.q_job           (f_job),
		.q_bucket        (f_bucket),
		.q_full          (q_full)
	);

	kcat_fifo #(
		.WIDTH (QW),
		.DEPTH (kcat_pkg::QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_push),
		.wr_data  ({f_bucket, f_job}),
		.is_full  (q_full),
		.rd_en    (q_pop),
		.rd_data  (q_rd),
		.is_empty (q_empty)
	);

	assign b_bucket = q_rd[QW-1 -: BI];
	assign b_job    = kcat_pkg::job_t'(q_rd[$bits(kcat_pkg::job_t)-1:0]);

	kcat_back #(
		.BUCKETS (BUCKETS),
		.ENTRIES (ENTRIES),
		.BI      (BI)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_job     (b_job),
		.q_bucket  (b_bucket),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	// Result ports.
	assign empty           = !res_valid;
	assign status          = res.status;
	assign total_modified  = res.tot_mod;
	assign total_canonical = res.tot_can;
	assign total_coverage  = res.tot_cov;
	assign saturated       = res.sat;
	assign key_position    = res.kpos;
endmodule

FILE: verif/keyed_count_aggregation_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_count_aggregation_table_checker
// Watches the request, result and register channels of the count table,
// keeps its own table of per-site totals and compares every popped result
// with the predicted one, in order.
// ----------------------------------------------------------------------------
module keyed_count_aggregation_table_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [kcat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           push,
	input  logic                           full,
	input  logic                           func,
	input  logic [30:0]                    position,
	input  logic [7:0]                     strand_char,
	input  logic [7:0]                     mod_char,
	input  logic [7:0]                     sample_index,
	input  logic [15:0]                    modified_count,
	input  logic [15:0]                    canonical_count,
	input  logic [15:0]                    coverage_count,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [2:0]                     status,
	input  logic [31:0]                    total_modified,
	input  logic [31:0]                    total_canonical,
	input  logic [31:0]                    total_coverage,
	input  logic                           saturated,
	input  logic signed [31:0]             key_position,
	output int                             errors,
	output int                             pending
);

	// Register copies and the predicted table contents.
	logic [7:0]     kept_code;
	logic           fold_strands;
	logic [95:0]    site_totals [logic [55:0]];
	int             sites_taken;
	kcat_pkg::res_t expected_results [$];

	// Adds one count to a running total, clamping at the maximum.
	function automatic logic [31:0] clamp_add(input logic [31:0] run, input logic [15:0] inc,
		inout logic clamped);
		logic [32:0] sum;
		sum = {1'b0, run} + {17'd0, inc};
		if (sum[32]) begin
			clamped = 1'b1;
			return kcat_pkg::TOTAL_MAX;
		end
		return sum[31:0];
	endfunction

	// Works out the result of one request and updates the predicted table.
	function automatic kcat_pkg::res_t predict_site(input logic fn, input logic [30:0] pos,
		input logic [7:0] strand, input logic [7:0] code, input logic [7:0] sample,
		input logic [15:0] add_mod, input logic [15:0] add_can, input logic [15:0] add_cov);
		kcat_pkg::res_t r;
		logic [31:0]    kpos;
		logic [7:0]     kstrand;
		logic [55:0]    key;
		logic [95:0]    tot;
		logic           hit;
		logic           clamped;
		r = '0;
		clamped = 1'b0;
		kpos = {1'b0, pos};
		kstrand = strand;
		r.kpos = kpos;
		if (code != kept_code || int'(sample) >= kcat_pkg::SAMPLES_DEF) begin
			r.status = kcat_pkg::ST_FILTERED;
			return r;
		end
		// Strand folding applies only to the four methylation-style codes.
		if (fold_strands && (kept_code == kcat_pkg::CODE_M || kept_code == kcat_pkg::CODE_H ||
			kept_code == kcat_pkg::CODE_C || kept_code == kcat_pkg::CODE_G)) begin
			if (strand == kcat_pkg::CODE_MINUS)
				kpos = kpos - 32'd1;
			kstrand = kcat_pkg::CODE_PLUS;
		end
		r.kpos = kpos;
		key = {kpos, kstrand, code, sample};
		hit = site_totals.exists(key);
		if (fn == kcat_pkg::FUNC_LOOKUP) begin
			if (hit) begin
				tot = site_totals[key];
				r.status = kcat_pkg::ST_HIT;
				{r.tot_mod, r.tot_can, r.tot_cov} = tot;
			end else begin
				r.status = kcat_pkg::ST_MISS;
			end
			return r;
		end
		if (hit) begin
			r.status = kcat_pkg::ST_ADDED;
			tot = site_totals[key];
		end else if (sites_taken >= kcat_pkg::ENTRIES_DEF) begin
			r.status = kcat_pkg::ST_FULL;
			return r;
		end else begin
			r.status = kcat_pkg::ST_NEW;
			sites_taken++;
			tot = '0;
		end
		r.tot_mod = clamp_add(tot[95:64], add_mod, clamped);
		r.tot_can = clamp_add(tot[63:32], add_can, clamped);
		r.tot_cov = clamp_add(tot[31:0], add_cov, clamped);
		r.sat = clamped;
		site_totals[key] = {r.tot_mod, r.tot_can, r.tot_cov};
		return r;
	endfunction

	// Track register writes, predict accepted requests, check popped results.
	always @(posedge clk or negedge arst_n) begin
		kcat_pkg::res_t want;
		if (!arst_n) begin
			kept_code = kcat_pkg::TARGET_RESET;
			fold_strands = 1'b0;
			site_totals.delete();
			sites_taken = 0;
			expected_results.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == kcat_pkg::CFG_TARGET)
					kept_code = cfg_data;
				else if (cfg_index == kcat_pkg::CFG_MERGE)
					fold_strands = cfg_data[0];
			end
			if (push && !full) begin
				expected_results.push_back(predict_site(func, position, strand_char, mod_char,
					sample_index, modified_count, canonical_count, coverage_count));
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result popped with no request outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (total_modified !== want.tot_mod) begin
						$error("total_modified: expected %0d, got %0d", want.tot_mod,
							total_modified);
						errors++;
					end
					if (total_canonical !== want.tot_can) begin
						$error("total_canonical: expected %0d, got %0d", want.tot_can,
							total_canonical);
						errors++;
					end
					if (total_coverage !== want.tot_cov) begin
						$error("total_coverage: expected %0d, got %0d", want.tot_cov,
							total_coverage);
						errors++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0d, got %0d", want.sat, saturated);
						errors++;
					end
					if (key_position !== want.kpos) begin
						$error("key_position: expected %0d, got %0d", $signed(want.kpos),
							key_position);
						errors++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

FILE: verif/keyed_count_aggregation_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_count_aggregation_table_test
// Drives count records into the table under several register settings and
// receiver/sender idling patterns, including a long back-pressure stretch;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module keyed_count_aggregation_table_test;

	localparam int STALL_LIMIT = 20000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [kcat_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                     cfg_data;
	logic                           push;
	logic                           full;
	logic                           func;
	logic [30:0]                    position;
	logic [7:0]                     strand_char;
	logic [7:0]                     mod_char;
	logic [7:0]                     sample_index;
	logic [15:0]                    modified_count;
	logic [15:0]                    canonical_count;
	logic [15:0]                    coverage_count;
	logic                           empty;
	logic                           pop;
	logic [2:0]                     status;
	logic [31:0]                    total_modified;
	logic [31:0]                    total_canonical;
	logic [31:0]                    total_coverage;
	logic                           saturated;
	logic signed [31:0]             key_position;
	int                             errors;
	int                             pending;

	int         tx_idle;
	int         rx_idle;
	int         hold_len;
	int         stall_cycles;
	logic [7:0] kept_now;

	keyed_count_aggregation_table u_dut (.*);

	keyed_count_aggregation_table_checker u_checker (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: random pop, or a long hold-off when one is asked for.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				pop <= 1'b0;
				hold_len--;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Watchdog on cycles in which no request, result or write moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("keyed_count_aggregation_table_test: done, errors");
				$finish;
			end
		end
	end

	// Offers one request and returns once it is taken; push stays high.
	task automatic send(input logic fn, input logic [30:0] pos, input logic [7:0] strand,
		input logic [7:0] code, input logic [7:0] sample, input logic [15:0] add_mod,
		input logic [15:0] add_can, input logic [15:0] add_cov);
		if ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push <= 1'b1;
		func <= fn;
		position <= pos;
		strand_char <= strand;
		mod_char <= code;
		sample_index <= sample;
		modified_count <= add_mod;
		canonical_count <= add_can;
		coverage_count <= add_cov;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Waits for the table to drain, then writes one register.
	task automatic write_reg(input logic [kcat_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
		push <= 1'b0;
		wait (pending == 0);
		repeat (60) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == kcat_pkg::CFG_TARGET)
			kept_now = value;
	endtask

	// A random record: mostly the kept code on a small set of sites so that
	// chains build up and repeat, with some fully random records mixed in.
	task automatic send_random();
		logic [7:0] strand;
		int         pick;
		pick = $urandom_range(9);
		strand = (pick < 4) ? kcat_pkg::CODE_PLUS :
			(pick < 8) ? kcat_pkg::CODE_MINUS : 8'($urandom_range(255));
		send(($urandom_range(3) == 0) ? kcat_pkg::FUNC_LOOKUP : kcat_pkg::FUNC_ACCUM,
			($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(63)),
			strand,
			($urandom_range(99) < 85) ? kept_now : 8'($urandom_range(255)),
			($urandom_range(4) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255)),
			($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
			($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
			($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		func = kcat_pkg::FUNC_ACCUM;
		position = '0;
		strand_char = '0;
		mod_char = '0;
		sample_index = '0;
		modified_count = '0;
		canonical_count = '0;
		coverage_count = '0;
		tx_idle = 0;
		rx_idle = 0;
		hold_len = 0;
		stall_cycles = 0;
		kept_now = kcat_pkg::TARGET_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed records with strand folding on.
		write_reg(kcat_pkg::CFG_MERGE, 8'd1);
		send(kcat_pkg::FUNC_ACCUM, 31'd0, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_M, 8'd0,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(kcat_pkg::FUNC_LOOKUP, 31'd0, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_M, 8'd0,
			16'd0, 16'd0, 16'd0);
		send(kcat_pkg::FUNC_ACCUM, 31'd1, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_M, 8'd0,
			16'd1, 16'd2, 16'd3);
		send(kcat_pkg::FUNC_LOOKUP, 31'd0, kcat_pkg::CODE_PLUS, kcat_pkg::CODE_M, 8'd0,
			16'd0, 16'd0, 16'd0);
		send(kcat_pkg::FUNC_ACCUM, 31'h7FFF_FFFF, kcat_pkg::CODE_PLUS, kcat_pkg::CODE_M,
			8'd255, 16'd0, 16'd0, 16'd0);
		send(kcat_pkg::FUNC_ACCUM, 31'h7FFF_FFFF, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_M,
			8'd255, 16'd5, 16'd6, 16'd7);
		send(kcat_pkg::FUNC_ACCUM, 31'd9, 8'd0, kcat_pkg::CODE_M, 8'd3,
			16'd10, 16'd10, 16'd10);
		send(kcat_pkg::FUNC_LOOKUP, 31'd9, 8'd255, kcat_pkg::CODE_M, 8'd3,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(kcat_pkg::FUNC_ACCUM, 31'd9, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_H, 8'd0,
			16'd1, 16'd1, 16'd1);
		send(kcat_pkg::FUNC_LOOKUP, 31'd9, kcat_pkg::CODE_PLUS, kcat_pkg::CODE_H, 8'd0,
			16'd1, 16'd1, 16'd1);
		send(kcat_pkg::FUNC_LOOKUP, 31'd5, kcat_pkg::CODE_PLUS, kcat_pkg::CODE_M, 8'd0,
			16'd0, 16'd0, 16'd0);
		// Folding off, and a code outside the folding set with folding on.
		write_reg(kcat_pkg::CFG_TARGET, kcat_pkg::CODE_H);
		write_reg(kcat_pkg::CFG_MERGE, 8'd0);
		send(kcat_pkg::FUNC_ACCUM, 31'd0, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_H, 8'd1,
			16'd4, 16'd4, 16'd4);
		send(kcat_pkg::FUNC_ACCUM, 31'd0, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_H, 8'd1,
			16'd4, 16'd4, 16'd4);
		send(kcat_pkg::FUNC_LOOKUP, 31'd0, kcat_pkg::CODE_MINUS, kcat_pkg::CODE_H, 8'd1,
			16'd0, 16'd0, 16'd0);
		write_reg(kcat_pkg::CFG_TARGET, 8'd0);
		write_reg(kcat_pkg::CFG_MERGE, 8'd1);
		send(kcat_pkg::FUNC_ACCUM, 31'd0, kcat_pkg::CODE_MINUS, 8'd0, 8'd0,
			16'd8, 16'd8, 16'd8);
		send(kcat_pkg::FUNC_LOOKUP, 31'd0, kcat_pkg::CODE_PLUS, 8'd0, 8'd0,
			16'd0, 16'd0, 16'd0);
		write_reg(kcat_pkg::CFG_TARGET, 8'd255);
		send(kcat_pkg::FUNC_ACCUM, 31'd2, kcat_pkg::CODE_MINUS, 8'd255, 8'd0,
			16'd8, 16'd8, 16'd8);
		send(kcat_pkg::FUNC_ACCUM, 31'd2, kcat_pkg::CODE_MINUS, 8'd0, 8'd0,
			16'd8, 16'd8, 16'd8);

		// Random phase with folding on and a sender that idles rarely; the
		// receiver holds off for a long stretch partway through.
		write_reg(kcat_pkg::CFG_TARGET, kcat_pkg::CODE_M);
		tx_idle = 16;
		rx_idle = 59;
		for (int i = 0; i < 630; i++) begin
			if (i == 200)
				hold_len = 400;
			if (i == 400) begin
				push <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			send_random();
		end

		// The other idling pattern, folding off.
		write_reg(kcat_pkg::CFG_TARGET, kcat_pkg::CODE_C);
		write_reg(kcat_pkg::CFG_MERGE, 8'd0);
		tx_idle = 59;
		rx_idle = 16;
		for (int i = 0; i < 630; i++)
			send_random();

		// No idling at all.
		write_reg(kcat_pkg::CFG_TARGET, kcat_pkg::CODE_G);
		write_reg(kcat_pkg::CFG_MERGE, 8'd1);
		tx_idle = 0;
		rx_idle = 0;
		for (int i = 0; i < 630; i++)
			send_random();
		push <= 1'b0;

		wait (pending == 0);
		repeat (60) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("keyed_count_aggregation_table_test: done, clean");
		else
			$display("keyed_count_aggregation_table_test: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
hdl/kcat_pkg.sv
hdl/kcat_fifo.sv
hdl/kcat_front.sv
hdl/kcat_back.sv
hdl/keyed_count_aggregation_table.sv
verif/keyed_count_aggregation_table_checker.sv
verif/keyed_count_aggregation_table_test.sv
